>>> rtl/core/pid_heading_controller_core_macros.svh
// Assertion macros for the PID heading controller core.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef PID_HEADING_CONTROLLER_CORE_MACROS_SVH
`define PID_HEADING_CONTROLLER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PHC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pid heading controller check failed");
`define PHC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pid heading controller reset check failed");
`else
`define PHC_ASSERT(label, clk, rst_n, prop)
`define PHC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/phc_pkg.sv
// Package for the PID heading controller core: widths, constants, register map.
// No dependencies.
`default_nettype none
package phc_pkg;

    localparam int ANGLE_W   = 16;
    localparam int GAIN_W    = 20;
    localparam int LIMIT_W   = 10;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int SUM_W     = 32;
    localparam int DRIVE_W   = 11;
    localparam int PP_W      = GAIN_W + 1 + ERR_W;
    localparam int PI_W      = GAIN_W + 1 + SUM_W;
    localparam int PD_W      = GAIN_W + 1 + DIFF_W;
    localparam int RAW_W     = 54;
    localparam int FRAC_SHIFT = 20;
    localparam int FLOOR_W   = RAW_W - FRAC_SHIFT;
    localparam int VAL_W     = FLOOR_W + 1;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [VAL_W-1:0] DRIVE_OFFSET = VAL_W'(90);

    localparam logic [ANGLE_W-1:0] TARGET_RST = '0;
    localparam logic [GAIN_W-1:0]  KP_RST     = GAIN_W'(26214);
    localparam logic [GAIN_W-1:0]  KI_RST     = '0;
    localparam logic [GAIN_W-1:0]  KD_RST     = GAIN_W'(66);
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(250);

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_KP     = 3'd1,
        REG_KI     = 3'd2,
        REG_KD     = 3'd3,
        REG_LIMIT  = 3'd4
    } t_reg_idx;

endpackage
`default_nettype wire

>>> rtl/core/pid_heading_controller_core.sv
// PID heading controller core: four-stage pipeline from heading word to drive word.
// Depends on phc_pkg and pid_heading_controller_core_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one measured heading per word,
//   signed Q12.4. Output channel (o_out_valid / i_out_stall) carries the offset and
//   clamped drive command plus a clamp flag. Both sides: a word moves on a rising
//   edge with valid high and stall low.
//   o_out_valid rises once the accepted word has passed the stage 1, 2 and 3
//   registers into the output register. One word per cycle is accepted while
//   o_in_stall is low; the integral and previous-error state update at acceptance,
//   and the three gain products each get a register stage before the final sum.
//   Stages hold their word when the one downstream is full and stalled; empty
//   stages still take words, so input stalls only once the whole pipe is full.
//   Gains, setpoint and limit are written over the APB port; the user must write
//   them only while the block is idle (not enforced). Synchronous reset clears
//   all valids, the integral and previous error, and loads register defaults.
`default_nettype none
`include "pid_heading_controller_core_macros.svh"
module pid_heading_controller_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [phc_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [phc_pkg::DATA_W-1:0]          pwdata,
    output logic      [phc_pkg::DATA_W-1:0]          prdata,
    output logic                                     pready,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [phc_pkg::ANGLE_W-1:0]  i_measured_angle,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [phc_pkg::DRIVE_W-1:0]       o_drive_cmd,
    output logic                                     o_clamped
);
    import phc_pkg::*;

    // configuration registers
    logic signed [ANGLE_W-1:0] r_target_angle;
    logic [GAIN_W-1:0]         r_gain_prop;
    logic [GAIN_W-1:0]         r_gain_integ;
    logic [GAIN_W-1:0]         r_gain_deriv;
    logic [LIMIT_W-1:0]        r_drive_limit;

    logic     w_cfg_wr;
    t_reg_idx w_reg_idx;

    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_angle <= TARGET_RST;
            r_gain_prop    <= KP_RST;
            r_gain_integ   <= KI_RST;
            r_gain_deriv   <= KD_RST;
            r_drive_limit  <= LIMIT_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_TARGET: r_target_angle <= pwdata[ANGLE_W-1:0];
                REG_KP:     r_gain_prop    <= pwdata[GAIN_W-1:0];
                REG_KI:     r_gain_integ   <= pwdata[GAIN_W-1:0];
                REG_KD:     r_gain_deriv   <= pwdata[GAIN_W-1:0];
                REG_LIMIT:  r_drive_limit  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_TARGET: prdata = DATA_W'(unsigned'(r_target_angle));
            REG_KP:     prdata = DATA_W'(r_gain_prop);
            REG_KI:     prdata = DATA_W'(r_gain_integ);
            REG_KD:     prdata = DATA_W'(r_gain_deriv);
            REG_LIMIT:  prdata = DATA_W'(r_drive_limit);
            default:    prdata = '0;
        endcase
    end

    // pipeline control
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic w_en1, w_en2, w_en3, w_en4, w_in_accept;

    assign w_en4       = !r_out_valid || !i_out_stall;
    assign w_en3       = !r_s3_valid || w_en4;
    assign w_en2       = !r_s2_valid || w_en3;
    assign w_en1       = !r_s1_valid || w_en2;
    assign o_in_stall  = !w_en1;
    assign w_in_accept = i_in_valid && w_en1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en1) r_s1_valid  <= i_in_valid;
            if (w_en2) r_s2_valid  <= r_s1_valid;
            if (w_en3) r_s3_valid  <= r_s2_valid;
            if (w_en4) r_out_valid <= r_s3_valid;
        end
    end

    // stage 1: error, saturating integral, difference; state updates on accept
    logic signed [SUM_W-1:0]  r_error_sum, n_error_sum;
    logic signed [ERR_W-1:0]  r_prev_error, n_prev_error;
    logic signed [SUM_W:0]    w_sum_wide;
    logic signed [ERR_W-1:0]  r_s1_err;
    logic signed [SUM_W-1:0]  r_s1_sum;
    logic signed [DIFF_W-1:0] r_s1_diff, n_s1_diff;

    always_comb begin
        n_prev_error = ERR_W'(r_target_angle) - ERR_W'(i_measured_angle);
        w_sum_wide   = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(n_prev_error);
        if (w_sum_wide[SUM_W] != w_sum_wide[SUM_W-1]) begin
            n_error_sum = w_sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_error_sum = w_sum_wide[SUM_W-1:0];
        end
        n_s1_diff = DIFF_W'(n_prev_error) - DIFF_W'(r_prev_error);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_prev_error <= '0;
        end else if (w_in_accept) begin
            r_error_sum  <= n_error_sum;
            r_prev_error <= n_prev_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_err  <= n_prev_error;
            r_s1_sum  <= n_error_sum;
            r_s1_diff <= n_s1_diff;
        end
    end

    // stage 2: gain products
    logic signed [PP_W-1:0] r_s2_pp;
    logic signed [PI_W-1:0] r_s2_pi;
    logic signed [PD_W-1:0] r_s2_pd;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_pp <= PP_W'(PP_W'($signed({1'b0, r_gain_prop})) * PP_W'(r_s1_err));
            r_s2_pi <= PI_W'(PI_W'($signed({1'b0, r_gain_integ})) * PI_W'(r_s1_sum));
            r_s2_pd <= PD_W'(PD_W'($signed({1'b0, r_gain_deriv})) * PD_W'(r_s1_diff));
        end
    end

    // stage 3: raw sum
    logic signed [RAW_W-1:0] r_s3_raw;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_raw <= RAW_W'(r_s2_pp) + RAW_W'(r_s2_pi) + RAW_W'(r_s2_pd);
        end
    end

    // stage 4: floor, offset, clamp
    logic signed [FLOOR_W-1:0] w_floor;
    logic signed [VAL_W-1:0]   w_val;
    logic signed [VAL_W-1:0]   w_lim;
    logic signed [DRIVE_W-1:0] n_drive, r_drive;
    logic                      n_clamped, r_clamped;

    always_comb begin
        w_floor = r_s3_raw[RAW_W-1:FRAC_SHIFT];
        w_val   = w_floor[FLOOR_W-1] ? VAL_W'(w_floor) - DRIVE_OFFSET
                                     : VAL_W'(w_floor) + DRIVE_OFFSET;
        w_lim   = VAL_W'(r_drive_limit);
        if (w_val > w_lim) begin
            n_drive   = DRIVE_W'(r_drive_limit);
            n_clamped = 1'b1;
        end else if (w_val < -w_lim) begin
            n_drive   = -DRIVE_W'(r_drive_limit);
            n_clamped = 1'b1;
        end else begin
            n_drive   = w_val[DRIVE_W-1:0];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_drive_cmd = r_drive;
    assign o_clamped   = r_clamped;

    // signed reference points for the output checks
    logic signed [DRIVE_W-1:0] w_lim_drive;
    logic signed [DRIVE_W-1:0] w_offset_drive;
    logic                      w_at_limit;
    logic                      w_has_offset;

    assign w_lim_drive    = DRIVE_W'(r_drive_limit);
    assign w_offset_drive = DRIVE_W'(DRIVE_OFFSET);
    assign w_at_limit     = (o_drive_cmd == w_lim_drive) || (o_drive_cmd == -w_lim_drive);
    assign w_has_offset   = (o_drive_cmd >= w_offset_drive) || (o_drive_cmd <= -w_offset_drive);

    `PHC_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, w_in_accept |=> r_s1_valid)
    `PHC_ASSERT(a_clamp_at_limit, i_clk, i_rst_n, (o_out_valid && o_clamped) |-> w_at_limit)
    `PHC_ASSERT(a_unclamped_has_offset, i_clk, i_rst_n, (o_out_valid && !o_clamped) |-> w_has_offset)
    `PHC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> (!o_out_valid && !r_s1_valid))

endmodule
`default_nettype wire

>>> tb/pid_heading_controller_core_checker.sv
`timescale 1ns / 100ps
// Drive word checker for the PID heading controller core: follows APB register writes
// and both word channels, predicts every drive word and compares it in order.
// Depends on phc_pkg.
module pid_heading_controller_core_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [phc_pkg::ADDR_W-1:0]         paddr,
    input  logic [phc_pkg::DATA_W-1:0]         pwdata,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic signed [phc_pkg::ANGLE_W-1:0] i_measured_angle,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [phc_pkg::DRIVE_W-1:0] i_drive_cmd,
    input  logic                               i_clamped,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import phc_pkg::*;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } t_drive_word;

    localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< (SUM_W - 1));

    logic signed [ANGLE_W-1:0] setpoint;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
    logic [LIMIT_W-1:0]        limit;
    logic signed [SUM_W-1:0]   err_integral;
    logic signed [ERR_W-1:0]   last_err;
    t_drive_word               drive_queue[$];
    int                        fails;

    // one PID step; updates the integral and the last error
    function automatic t_drive_word steer_for(input logic signed [ANGLE_W-1:0] heading);
        longint      err;
        longint      sum;
        longint      raw;
        longint      val;
        longint      lim;
        t_drive_word word;
        err = longint'(setpoint) - longint'(heading);
        sum = longint'(err_integral) + err;
        if (sum > SUM_MAX) begin
            sum = SUM_MAX;
        end else if (sum < SUM_MIN) begin
            sum = SUM_MIN;
        end
        raw = longint'(kp) * err + longint'(ki) * sum
            + longint'(kd) * (err - longint'(last_err));
        err_integral = SUM_W'(sum);
        last_err     = ERR_W'(err);
        val = raw >>> FRAC_SHIFT;
        if (val >= 0) begin
            val = val + longint'(DRIVE_OFFSET);
        end else begin
            val = val - longint'(DRIVE_OFFSET);
        end
        lim = longint'(limit);
        word.clamped = 1'b0;
        if (val > lim) begin
            val = lim;
            word.clamped = 1'b1;
        end else if (val < -lim) begin
            val = -lim;
            word.clamped = 1'b1;
        end
        word.drive = DRIVE_W'(val);
        return word;
    endfunction

    always @(posedge i_clk) begin : track
        t_drive_word want;
        if (!i_rst_n) begin
            setpoint     = TARGET_RST;
            kp           = KP_RST;
            ki           = KI_RST;
            kd           = KD_RST;
            limit        = LIMIT_RST;
            err_integral = '0;
            last_err     = '0;
            drive_queue.delete();
            fails        = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_TARGET: setpoint = pwdata[ANGLE_W-1:0];
                    REG_KP:     kp       = pwdata[GAIN_W-1:0];
                    REG_KI:     ki       = pwdata[GAIN_W-1:0];
                    REG_KD:     kd       = pwdata[GAIN_W-1:0];
                    REG_LIMIT:  limit    = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (drive_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected drive word: drive %0d clamped %0b",
                                 i_drive_cmd, i_clamped);
                    end
                end else begin
                    want = drive_queue.pop_front();
                    if (want.drive !== i_drive_cmd || want.clamped !== i_clamped) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("drive word mismatch: expected %0d/%0b, got %0d/%0b",
                                     want.drive, want.clamped, i_drive_cmd, i_clamped);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                drive_queue.push_back(steer_for(i_measured_angle));
            end
        end
        o_fail_count <= fails;
        o_pending    <= drive_queue.size();
    end

endmodule

>>> tb/pid_heading_controller_core_test.sv
`timescale 1ns / 100ps
// Top of the PID heading controller core testbench: clock, reset, APB register setup
// and heading words with random idling on both channels; the checker gives the count.
// Depends on phc_pkg, pid_heading_controller_core and pid_heading_controller_core_checker.
module pid_heading_controller_core_test;
    import phc_pkg::*;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int SETTLE_WAIT  = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 165;
    localparam int WINDUP_UP    = 20;
    localparam int WINDUP_DOWN  = 20;
    localparam int GAIN_MAX     = (1 << GAIN_W) - 1;
    localparam int LIMIT_MAX    = (1 << LIMIT_W) - 1;
    localparam logic [2:0] REG_SPARE = 3'd5;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [ANGLE_W-1:0] i_measured_angle;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [DRIVE_W-1:0] o_drive_cmd;
    logic                      o_clamped;

    int                        fail_count;
    int                        pending;
    bit                        sender_calm;
    bit                        receiver_calm;
    bit                        hold_req;
    logic signed [ANGLE_W-1:0] heading;
    logic signed [ANGLE_W-1:0] cur_target;

    pid_heading_controller_core dut (
        .i_clk, .i_rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_in_valid, .o_in_stall, .i_measured_angle,
        .o_out_valid, .i_out_stall, .o_drive_cmd, .o_clamped
    );

    pid_heading_controller_core_checker drive_check (
        .i_clk, .i_rst_n,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .i_in_valid, .i_in_stall(o_in_stall), .i_measured_angle,
        .i_out_valid(o_out_valid), .i_out_stall, .i_drive_cmd(o_drive_cmd),
        .i_clamped(o_clamped),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("pid_heading_controller_core regression: fail");
        $finish;
    end

    // output side: random stalls, or one long hold when asked
    initial begin : receiver
        int held;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_stall = !receiver_calm && ($urandom_range(0, 99) < 24);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_settings(input logic signed [ANGLE_W-1:0] target,
                                 input int kp, input int ki, input int kd,
                                 input int limit);
        cur_target = target;
        write_reg(REG_TARGET, DATA_W'(target));
        write_reg(REG_KP, DATA_W'(kp));
        write_reg(REG_KI, DATA_W'(ki));
        write_reg(REG_KD, DATA_W'(kd));
        write_reg(REG_LIMIT, DATA_W'(limit));
    endtask

    task automatic send_heading(input logic signed [ANGLE_W-1:0] value);
        int gap;
        @(negedge i_clk);
        i_in_valid       = 1'b1;
        i_measured_angle = value;
        do @(posedge i_clk); while (o_in_stall);
        if (!sender_calm && $urandom_range(0, 99) < 24) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop offering, wait for every drive word, then let the pipe go quiet
    task automatic settle;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    function automatic int pick_gain();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, GAIN_MAX);
        end
        return $urandom_range(0, 65535);
    endfunction

    // full-range jumps, near-setpoint values, or a slow drift
    function automatic logic signed [ANGLE_W-1:0] next_heading();
        case ($urandom_range(0, 3))
            0:       heading = ANGLE_W'($urandom);
            1:       heading = cur_target + ANGLE_W'($urandom_range(0, 512) - 256);
            default: heading = heading + ANGLE_W'($urandom_range(0, 128) - 64);
        endcase
        return heading;
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_in_valid       = 1'b0;
        i_measured_angle = '0;
        sender_calm      = 1'b0;
        receiver_calm    = 1'b0;
        hold_req         = 1'b0;
        heading          = '0;
        cur_target       = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings, heading extremes
        send_heading('0);
        send_heading(ANGLE_MAX);
        send_heading(ANGLE_MIN);
        send_heading(-16'sd1);
        send_heading(16'sd1);
        // half-unit drive: negative floors to -1, positive to 0
        settle;
        load_settings('0, 32768, 0, 0, 250);
        send_heading(16'sd16);
        send_heading(-16'sd16);
        send_heading('0);
        // zero limit always clamps
        settle;
        write_reg(REG_LIMIT, '0);
        send_heading(ANGLE_MAX);
        send_heading(ANGLE_MIN);
        send_heading('0);
        // spare register index is ignored
        settle;
        write_reg(REG_SPARE, '1);
        send_heading(16'sd100);
        settle;
        load_settings('0, GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX);
        send_heading(ANGLE_MIN);
        send_heading(ANGLE_MAX);
        send_heading(ANGLE_MIN);

        for (phase = 0; phase < PHASES; phase++) begin
            settle;
            case (phase)
                0: load_settings(ANGLE_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX);
                1: load_settings(ANGLE_MIN, 0, 0, 0, 0);
                default: load_settings(ANGLE_W'($urandom), pick_gain(),
                                       ($urandom_range(0, 9) == 0) ?
                                           $urandom_range(0, GAIN_MAX) :
                                           $urandom_range(0, 255),
                                       pick_gain(),
                                       ($urandom_range(0, 4) == 0) ?
                                           LIMIT_MAX : $urandom_range(0, LIMIT_MAX));
            endcase
            sender_calm   = (phase == 4);
            receiver_calm = (phase == 4);
            hold_req      = (phase == 6);
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (phase == 8 && n == PHASE_WORDS / 2) begin
                    settle;
                end
                send_heading(next_heading());
            end
        end

        // integral ramp up with large errors, then back down
        settle;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        load_settings(ANGLE_MAX, 0, 1, 0, LIMIT_MAX);
        for (n = 0; n < WINDUP_UP; n++) begin
            send_heading(ANGLE_MIN + ANGLE_W'($urandom_range(0, 15)));
        end
        settle;
        load_settings(ANGLE_MIN, 0, 1, 0, LIMIT_MAX);
        for (n = 0; n < WINDUP_DOWN; n++) begin
            send_heading(ANGLE_MAX - ANGLE_W'($urandom_range(0, 15)));
        end

        settle;
        if (fail_count == 0 && pending == 0) begin
            $display("pid_heading_controller_core regression: pass");
        end else begin
            $display("pid_heading_controller_core regression: fail");
        end
        $finish;
    end

endmodule
